FILE: design/sbc_pkg.sv
`default_nettype none

package sbc_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int MAX_HOLD        = 32;
    localparam int KNOB_WIDTH      = 8;
    localparam int KNOB_RANGE      = 1 << KNOB_WIDTH;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int SHIFT_WIDTH     = $clog2(SAMPLE_WIDTH);
    localparam int HOLD_WIDTH      = $clog2(MAX_HOLD);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [SHIFT_WIDTH-1:0] shift_t;
    typedef logic [HOLD_WIDTH-1:0] hold_t;
    typedef logic [KNOB_WIDTH-1:0] knob_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    typedef logic [KNOB_RANGE-1:0][SHIFT_WIDTH-1:0] shift_lut_t;
    typedef logic [KNOB_RANGE-1:0][HOLD_WIDTH-1:0] reload_lut_t;

    localparam cfg_index_t CFG_BITS_KNOB = cfg_index_t'(0);
    localparam cfg_index_t CFG_RATE_KNOB = cfg_index_t'(1);

    localparam knob_t KNOB_RESET = knob_t'(KNOB_RANGE - 1);

    // depth = 1 + round(k*15/255); the table holds the rounding shift, zero means pass
    function automatic shift_lut_t build_shift_lut();
        shift_lut_t lut;
        int depth;
        for (int k = 0; k < KNOB_RANGE; k++)
        begin
            depth = 1 + (2 * k + 17) / 34;
            if (depth >= SAMPLE_WIDTH)
                lut[k] = '0;
            else
                lut[k] = SHIFT_WIDTH'(SAMPLE_WIDTH - depth);
        end
        return lut;
    endfunction

    // step = MAX_HOLD - round(k*(MAX_HOLD-1)/255); the table holds step - 1
    function automatic reload_lut_t build_reload_lut();
        reload_lut_t lut;
        int r;
        int st;
        for (int k = 0; k < KNOB_RANGE; k++)
        begin
            r  = (2 * k * (MAX_HOLD - 1) + 255) / 510;
            st = MAX_HOLD - r;
            if (st < 1)
                st = 1;
            lut[k] = HOLD_WIDTH'(st - 1);
        end
        return lut;
    endfunction

    localparam shift_lut_t  SHIFT_LUT  = build_shift_lut();
    localparam reload_lut_t RELOAD_LUT = build_reload_lut();

endpackage

`default_nettype wire

FILE: design/stereo_bitcrusher_sample_hold.sv
`default_nettype none

// Stereo bit crusher with sample-and-hold. Takes one stereo Q1.15 frame per
// transaction and returns one frame per transaction, in order. Throughput is
// one frame per clock cycle when the output does not stall. A frame passes the
// input register, then the output register, which also holds the crushed pair
// for the hold. The input stalls only while the output register is full and stalled.
// bits_knob (index 0) and rate_knob (index 1) are decoded into a rounding
// shift and a hold reload value when written; other indexes are ignored.
// A new knob value takes effect at the next reload of the hold counter.
module stereo_bitcrusher_sample_hold
    import sbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire sample_t    left_in,
    input  wire sample_t    right_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output sample_t         left_out,
    output sample_t         right_out,
    input  wire logic       cfg_write,
    input  wire cfg_index_t cfg_index,
    input  wire knob_t      cfg_data
);

    localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);

    // round half-up to a multiple of 2^sh, saturate on positive overflow
    function automatic sample_t crush(input sample_t s, input shift_t sh);
        logic [SAMPLE_WIDTH:0] half;
        logic [SAMPLE_WIDTH:0] mask;
        logic [SAMPLE_WIDTH:0] t;
        if (sh == '0)
            return s;
        half = (SAMPLE_WIDTH+1)'(1) << (sh - shift_t'(1));
        mask = ~(((SAMPLE_WIDTH+1)'(1) << sh) - (SAMPLE_WIDTH+1)'(1));
        t    = ({s[SAMPLE_WIDTH-1], s} + half) & mask;
        if (!t[SAMPLE_WIDTH] && t[SAMPLE_WIDTH-1])
            return SAMPLE_MAX;
        return sample_t'(t[SAMPLE_WIDTH-1:0]);
    endfunction

    shift_t  shift_reg;
    hold_t   reload_reg;
    hold_t   hold_count_reg;
    hold_t   hold_count_next;
    logic    s1_valid_reg;
    sample_t s1_left_reg;
    sample_t s1_right_reg;
    logic    out_valid_reg;
    sample_t held_left_reg;
    sample_t held_right_reg;
    sample_t held_left_next;
    sample_t held_right_next;
    logic    s2_ready;
    logic    s1_adv;
    logic    in_accept;

    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign left_out  = held_left_reg;
    assign right_out = held_right_reg;

    always_comb
    begin
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        if (hold_count_reg == '0)
        begin
            held_left_next  = crush(s1_left_reg, shift_reg);
            held_right_next = crush(s1_right_reg, shift_reg);
            hold_count_next = reload_reg;
        end
        else
        begin
            hold_count_next = hold_count_reg - hold_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= SHIFT_LUT[KNOB_RESET];
            reload_reg <= RELOAD_LUT[KNOB_RESET];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BITS_KNOB: shift_reg  <= SHIFT_LUT[cfg_data];
                CFG_RATE_KNOB: reload_reg <= RELOAD_LUT[cfg_data];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_count_reg <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                hold_count_reg <= hold_count_next;
                held_left_reg  <= held_left_next;
                held_right_reg <= held_right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_left_reg  <= left_in;
            s1_right_reg <= right_in;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && hold_count_reg != '0) |=>
            $stable(held_left_reg) && $stable(held_right_reg))
    else $error("held pair changed during a hold");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && hold_count_reg != '0) |=>
            hold_count_reg == $past(hold_count_reg) - hold_t'(1))
    else $error("hold counter did not count down");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
    else $error("frame lost between input and output register");
`endif

endmodule

`default_nettype wire
